>>> design/ltps_pkg.sv
// Shared types and constants of the twin prime search block.
// No dependencies; every other file of the block imports this package.
package ltps_pkg;

   // Width of the prime fields on the result channel.
   localparam int PRIME_WIDTH = 16;

   // The smallest larger prime of a pair whose smaller prime is at least 3.
   localparam int SMALLEST_UPPER = 5;

   // Distance between the two primes of a pair.
   localparam int TWIN_GAP = 2;

   // Status that the remainder unit reports to the search controller.
   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } ltps_div_status_type;

endpackage

>>> design/ltps_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ltps_pkg for the width of the prime fields.
interface ltps_req_if #(
   parameter int VALUE_WIDTH = 16
) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink (input valid, input limit, output ready);
endinterface

interface ltps_rsp_if import ltps_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [PRIME_WIDTH-1:0] lower_prime;
   logic [PRIME_WIDTH-1:0] upper_prime;

   modport source (output valid, output found, output lower_prime, output upper_prime,
                   input ready);
   modport sink (input valid, input found, input lower_prime, input upper_prime,
                 output ready);
endinterface

>>> design/ltps_rem_unit.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring style.
// Depends on ltps_pkg for the status struct.
module ltps_rem_unit import ltps_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VALUE_WIDTH-1:0]   dividend,
   input  logic [VALUE_WIDTH-1:0]   divisor,
   output ltps_div_status_type      status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         count_in = CNT_W'(VALUE_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder never reaches twice the divisor, so one
         // compare and subtract per bit is enough.
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

>>> design/largest_twin_prime_search.sv
// Largest twin prime pair at or below a limit, by trial division.
// Usage:
//   A request beat on req_ch carries a limit. The block searches downward
//   from the limit for the largest pair (p, p+2) of primes with p at least 3
//   and answers with one response beat on rsp_ch: found, lower_prime and
//   upper_prime (both zero when nothing is found, as for any limit below 5).
//   One request is worked on at a time; req_ch.ready is high while the
//   search controller is idle, also while a finished response still waits.
// Search:
//   Each trial division runs through the bit-serial remainder unit. A
//   candidate n is tried with divisors from 2 up to floor(sqrt(n)) if n is
//   prime, and fewer if a small divisor hits. Candidates are tested downward
//   until a pair is found; a limit below 5 gets its response with no division.
// Reset: synchronous, active high; the controller returns to idle, any
//   search in progress is dropped and no response is pending.
// Stall: a response waits in the output register until rsp_ch.ready; a
//   search that finishes meanwhile holds its result until that register frees.
module largest_twin_prime_search import ltps_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic  clock,
   input  logic  reset,
   ltps_req_if.sink   req_ch,
   ltps_rsp_if.source rsp_ch
);

   localparam int W = VALUE_WIDTH;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_NEXT   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic [W-1:0] UPPER_MIN = W'(SMALLEST_UPPER);
   localparam logic [W-1:0] GAP       = W'(TWIN_GAP);
   localparam logic [W-1:0] FIRST_DIV = W'(2);
   localparam logic [W:0]   FIRST_SQ  = (W + 1)'(4);

   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           cand_ff, cand_in;     // larger member under test
   logic [W-1:0]           n_ff, n_in;           // number being tested now
   logic                   second_ff, second_in; // testing cand - 2
   logic [W-1:0]           d_ff, d_in;           // trial divisor
   logic [W:0]             sq_ff, sq_in;         // d_ff squared
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [PRIME_WIDTH-1:0] rsp_lower_ff, rsp_lower_in;
   logic [PRIME_WIDTH-1:0] rsp_upper_ff, rsp_upper_in;

   logic                   div_start;
   logic                   past_root;
   logic                   out_free;
   logic [W-1:0]           cand_less;
   ltps_div_status_type    div_status;

   ltps_rem_unit #(
      .VALUE_WIDTH (W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .status   (div_status)
   );

   assign past_root = (sq_ff > {1'b0, n_ff});
   assign div_start = (state_ff == S_CHECK) && !past_root;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cand_less = cand_ff - W'(1);

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      n_in         = n_ff;
      second_in    = second_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_lower_in = rsp_lower_ff;
      rsp_upper_in = rsp_upper_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cand_in   = req_ch.limit;
               n_in      = req_ch.limit;
               second_in = 1'b0;
               d_in      = FIRST_DIV;
               sq_in     = FIRST_SQ;
               found_in  = 1'b0;
               state_in  = (req_ch.limit < UPPER_MIN) ? S_FINISH : S_CHECK;
            end
         end
         S_CHECK: begin
            // No divisor up to the square root divides n, so n is prime.
            if (past_root) begin
               if (second_ff) begin
                  found_in = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  n_in      = cand_ff - GAP;
                  second_in = 1'b1;
                  d_in      = FIRST_DIV;
                  sq_in     = FIRST_SQ;
               end
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (div_status.zero) begin
                  state_in = S_NEXT;
               end else begin
                  d_in     = d_ff + W'(1);
                  sq_in    = sq_ff + {d_ff, 1'b1};
                  state_in = S_CHECK;
               end
            end
         end
         S_NEXT: begin
            if (cand_ff == UPPER_MIN) begin
               state_in = S_FINISH;
            end else begin
               cand_in   = cand_less;
               n_in      = cand_less;
               second_in = 1'b0;
               d_in      = FIRST_DIV;
               sq_in     = FIRST_SQ;
               state_in  = S_CHECK;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_lower_in = found_ff ? PRIME_WIDTH'(cand_ff - GAP) : '0;
               rsp_upper_in = found_ff ? PRIME_WIDTH'(cand_ff) : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      n_ff         <= n_in;
      second_ff    <= second_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_upper_ff <= rsp_upper_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.lower_prime = rsp_lower_ff;
   assign rsp_ch.upper_prime = rsp_upper_ff;

   // A found pair always differs by the twin gap.
   a_pair_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.found) |->
         (PRIME_WIDTH'(rsp_ch.upper_prime - rsp_ch.lower_prime) == PRIME_WIDTH'(TWIN_GAP)))
      else $error("found pair does not differ by the twin gap");

   // A miss reports both primes as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |->
         (rsp_ch.lower_prime == '0 && rsp_ch.upper_prime == '0))
      else $error("miss reports nonzero primes");

   // The remainder unit is never restarted while a division is under way.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("remainder unit restarted while busy");

   // A division is only started for a number of at least 3 and a divisor of at least 2.
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (n_ff >= W'(3) && d_ff >= FIRST_DIV))
      else $error("division started with out-of-range operands");

endmodule
